// ===== rtl/bad_pkg.sv =====
package bad_pkg;

    // channel and payload widths
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned SIZE_REG_W  = 13;
    localparam int unsigned FACTOR_REG_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 2'd2;

    // saturated channel mean and fully opaque alpha
    localparam logic [CHAN_W-1:0] MEAN_MAX     = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // quotient bits produced one per cycle
    localparam int unsigned DIV_STEPS = 8;

    // edges from an accepted input word to a fresh result word on an idle output
    localparam int unsigned RESULT_LATENCY = 11;

endpackage

// ===== rtl/box_average_image_downscaler.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: red, green, blue, alpha_in
// m_        out  m_tvalid/m_tready  m_tdata: color565, alpha_out; m_tuser: translucent_seen;
//                                   m_tlast: last_pixel
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (width, height, factor)
//
// a pixel that closes no block: column-sum read, then add and write back
// a pixel that closes a block: read, write back, the shared bit-per-cycle divider over all
// four channels, then the load into the output register
// the output register holds one result word; a stalled sink holds the block in its last state
// aresetn is synchronous, active low; the column-sum memory needs no clearing pass
module box_average_image_downscaler
    import bad_pkg::*;
#(
    parameter int unsigned MAX_OUT_WIDTH   = 512,
    parameter int unsigned MAX_FACTOR      = 16,
    parameter int unsigned MAX_SOURCE_SIZE = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // red, green, blue, alpha_in
    // output pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // color565, alpha_out
    output logic                  m_tuser,    // translucent_seen
    output logic                  m_tlast,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned XW   = (MAX_SOURCE_SIZE > 1) ? $clog2(MAX_SOURCE_SIZE) : 1;
    localparam int unsigned WW   = $clog2(MAX_SOURCE_SIZE + 1);
    localparam int unsigned KW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int unsigned FW   = $clog2(MAX_FACTOR + 1);
    localparam int unsigned NW   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int unsigned OCW  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int unsigned SUMW = $clog2(MAX_FACTOR * MAX_SOURCE_SIZE * 255 + 1);
    localparam int unsigned RW   = (SUMW > NW + 8) ? SUMW : NW + 8;
    localparam int unsigned ENTW = 4 * SUMW;
    localparam int unsigned STW  = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ACCUM = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers, raw
    logic [SIZE_REG_W-1:0]   width_cfg_reg;
    logic [SIZE_REG_W-1:0]   height_cfg_reg;
    logic [FACTOR_REG_W-1:0] factor_cfg_reg;

    // position counters
    logic [XW-1:0]  src_x_reg, src_x_next;
    logic [XW-1:0]  src_y_reg, src_y_next;
    logic [KW-1:0]  rib_reg, rib_next;
    logic [KW-1:0]  cib_reg, cib_next;
    logic [OCW-1:0] ocol_reg, ocol_next;
    logic           trans_reg, trans_next;

    // per-item registers
    logic [CHAN_W-1:0] pix_reg [4];
    logic [OCW-1:0]    addr_reg;
    logic              first_reg;
    logic              emit_reg;
    logic              last_reg;
    logic [NW-1:0]     n_reg;

    // column-sum memory and its read register
    logic [ENTW-1:0] sum_mem [MAX_OUT_WIDTH];
    logic [ENTW-1:0] rd_data_reg;

    // divider
    logic [RW-1:0]     rem_reg [4];
    logic [RW-1:0]     div_reg;
    logic [CHAN_W-1:0] quo_reg [4];
    logic [3:0]        sat_reg;
    logic [STW-1:0]    step_reg;

    // output register
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    logic s_accept;
    logic cfg_accept;
    logic out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // effective sizes: zero acts as one, oversize saturates
    logic [WW-1:0] w_eff, h_eff;
    logic [FW-1:0] f_eff;

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_SOURCE_SIZE)) begin
            w_eff = WW'(MAX_SOURCE_SIZE);
        end else begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = WW'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_SOURCE_SIZE)) begin
            h_eff = WW'(MAX_SOURCE_SIZE);
        end else begin
            h_eff = WW'(height_cfg_reg);
        end
        if (factor_cfg_reg == '0) begin
            f_eff = FW'(1);
        end else if (32'(factor_cfg_reg) > 32'(MAX_FACTOR)) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(factor_cfg_reg);
        end
    end

    // block position decode for the pixel at the input
    logic [WW:0]      x_plus1, y_plus1;
    logic [FW-1:0]    cib_plus1, rib_plus1;
    logic             row_end, col_end, image_bottom, blockrow_end;
    logic             first_px, emit_px, last_px;
    logic [NW-1:0]    n_px;

    always_comb begin
        x_plus1      = (WW + 1)'(src_x_reg) + (WW + 1)'(1);
        y_plus1      = (WW + 1)'(src_y_reg) + (WW + 1)'(1);
        cib_plus1    = FW'(cib_reg) + FW'(1);
        rib_plus1    = FW'(rib_reg) + FW'(1);
        row_end      = x_plus1 >= (WW + 1)'(w_eff);
        image_bottom = y_plus1 >= (WW + 1)'(h_eff);
        col_end      = (cib_plus1 >= f_eff) || row_end;
        blockrow_end = (rib_plus1 >= f_eff) || image_bottom;
        first_px     = (rib_reg == '0) && (cib_reg == '0);
        emit_px      = col_end && blockrow_end;
        last_px      = row_end && image_bottom;
        n_px         = NW'((2 * FW)'(cib_plus1) * (2 * FW)'(rib_plus1));
    end

    // counter advance on an accepted pixel, restart on a config write to width, height or factor
    always_comb begin
        src_x_next = src_x_reg;
        src_y_next = src_y_reg;
        rib_next   = rib_reg;
        cib_next   = cib_reg;
        ocol_next  = ocol_reg;
        if (cfg_accept && (cfg_index == CFG_SOURCE_WIDTH || cfg_index == CFG_SOURCE_HEIGHT
                           || cfg_index == CFG_SHRINK_FACTOR)) begin
            src_x_next = '0;
            src_y_next = '0;
            rib_next   = '0;
            cib_next   = '0;
            ocol_next  = '0;
        end else if (s_accept) begin
            if (row_end) begin
                src_x_next = '0;
                cib_next   = '0;
                ocol_next  = '0;
                if (image_bottom) begin
                    src_y_next = '0;
                    rib_next   = '0;
                end else begin
                    src_y_next = XW'(y_plus1);
                    rib_next   = blockrow_end ? '0 : KW'(rib_plus1);
                end
            end else begin
                src_x_next = XW'(x_plus1);
                if (col_end) begin
                    cib_next  = '0;
                    ocol_next = (ocol_reg == OCW'(MAX_OUT_WIDTH - 1)) ? '0
                                                                       : ocol_reg + OCW'(1);
                end else begin
                    cib_next = KW'(cib_plus1);
                end
            end
        end
    end

    // read-modify sums
    logic [SUMW-1:0] new_sum [4];
    logic [3:0]      sat_now;
    logic [RW-1:0]   div_top;

    always_comb begin
        div_top = RW'(n_reg) << 8;
        for (int c = 0; c < 4; c++) begin
            new_sum[c] = first_reg ? SUMW'(pix_reg[c])
                                   : rd_data_reg[c*SUMW +: SUMW] + SUMW'(pix_reg[c]);
            sat_now[c] = RW'(new_sum[c]) >= div_top;
        end
    end

    // final means and packing
    logic [CHAN_W-1:0] mean [4];
    logic              seen;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mean[c] = sat_reg[c] ? MEAN_MAX : quo_reg[c];
        end
        seen = trans_reg || (mean[3] != ALPHA_OPAQUE);
    end

    // state sequencing
    always_comb begin
        state_next = state_reg;
        trans_next = trans_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (step_reg == '0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    trans_next = last_reg ? 1'b0 : seen;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_accept && (cfg_index == CFG_SOURCE_WIDTH || cfg_index == CFG_SOURCE_HEIGHT
                           || cfg_index == CFG_SHRINK_FACTOR)) begin
            trans_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= SIZE_REG_W'(1);
            height_cfg_reg <= SIZE_REG_W'(1);
            factor_cfg_reg <= FACTOR_REG_W'(1);
            src_x_reg      <= '0;
            src_y_reg      <= '0;
            rib_reg        <= '0;
            cib_reg        <= '0;
            ocol_reg       <= '0;
            trans_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            src_x_reg <= src_x_next;
            src_y_reg <= src_y_next;
            rib_reg   <= rib_next;
            cib_reg   <= cib_next;
            ocol_reg  <= ocol_next;
            trans_reg <= trans_next;
            if (cfg_accept) begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  width_cfg_reg  <= SIZE_REG_W'(cfg_data);
                    CFG_SOURCE_HEIGHT: height_cfg_reg <= SIZE_REG_W'(cfg_data);
                    CFG_SHRINK_FACTOR: factor_cfg_reg <= FACTOR_REG_W'(cfg_data);
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // column-sum memory: read on accept, write back in the accumulate cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= sum_mem[ocol_reg];
        end
        if (state_reg == ST_ACCUM) begin
            sum_mem[addr_reg] <= {new_sum[3], new_sum[2], new_sum[1], new_sum[0]};
        end
    end

    // item capture, divider and output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int c = 0; c < 4; c++) begin
                pix_reg[c] <= s_tdata[c*CHAN_W +: CHAN_W];
            end
            addr_reg  <= ocol_reg;
            first_reg <= first_px;
            emit_reg  <= emit_px;
            last_reg  <= last_px;
            n_reg     <= n_px;
        end
        // load the dividend and the divisor aligned to the top quotient bit
        if (state_reg == ST_ACCUM) begin
            for (int c = 0; c < 4; c++) begin
                rem_reg[c] <= RW'(new_sum[c]);
            end
            sat_reg  <= sat_now;
            div_reg  <= RW'(n_reg) << (DIV_STEPS - 1);
            step_reg <= STW'(DIV_STEPS - 1);
        end
        // one restoring step per cycle on all four channels
        if (state_reg == ST_DIV) begin
            for (int c = 0; c < 4; c++) begin
                if (rem_reg[c] >= div_reg) begin
                    rem_reg[c] <= rem_reg[c] - div_reg;
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b1};
                end else begin
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
            end
            div_reg  <= div_reg >> 1;
            step_reg <= step_reg - STW'(1);
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {mean[3], mean[0][7:3], mean[1][7:2], mean[2][7:3]};
            m_tuser_reg <= seen;
            m_tlast_reg <= last_reg;
        end
    end

endmodule

// ===== rtl/bad_checker.sv =====
module bad_checker
    import bad_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,    // color565, alpha_out
    input logic                  m_tuser,    // translucent_seen
    input logic                  m_tlast
);

    // a stalled result word holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result word changed while stalled");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // one pixel at a time: no input word right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pixel is still in work");

    // a rising result word traces back to an accepted pixel by the input-to-result latency
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, RESULT_LATENCY))
        else $error("result word without a matching input pixel");

endmodule

bind box_average_image_downscaler bad_checker u_bad_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bad_pkg::*;

    localparam int unsigned OUT_COLS      = 512;
    localparam int unsigned FACTOR_MAX    = 16;
    localparam int unsigned SOURCE_MAX    = 4096;
    localparam int unsigned RANDOM_PIXELS = 420;
    localparam int unsigned SETTLE_CYCLES = 2 * RESULT_LATENCY;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // input word, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic        last_pixel;
        logic        translucent_seen;
        logic [7:0]  alpha_out;
        logic [15:0] color565;
    } scaled_pixel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;    // red, green, blue, alpha_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // color565, alpha_out
    logic                  m_tuser;           // translucent_seen
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    box_average_image_downscaler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #1 aclk = ~aclk;

    // shadow registers and scan position of the downscaler
    logic [SIZE_REG_W-1:0]   reg_width  = 13'd1;
    logic [SIZE_REG_W-1:0]   reg_height = 13'd1;
    logic [FACTOR_REG_W-1:0] reg_factor = 5'd1;
    int unsigned col_sum [OUT_COLS][4];
    int unsigned pos_x, pos_y, row_in_blk, col_in_blk, out_col;
    bit          translucent;
    scaled_pixel_t expected_pixels [$];

    bit          src_fast, sink_fast;
    int unsigned pixels_sent, results_checked, reg_writes, mismatch_count;
    int unsigned cycle_count = 0;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void begin_new_image();
        pos_x       = 0;
        pos_y       = 0;
        row_in_blk  = 0;
        col_in_blk  = 0;
        out_col     = 0;
        translucent = 1'b0;
    endfunction

    // accumulate one source pixel and queue the block mean it completes, if any
    function automatic void downscale_pixel(pixel_t px);
        int unsigned w, h, f, n, q;
        int unsigned chan [4];
        logic [7:0]  mean [4];
        bit          row_end, col_end, at_bottom, blockrow_end;
        scaled_pixel_t res;
        w = clamp_size(32'(reg_width), SOURCE_MAX);
        h = clamp_size(32'(reg_height), SOURCE_MAX);
        f = clamp_size(32'(reg_factor), FACTOR_MAX);
        chan[0] = 32'(px.red);
        chan[1] = 32'(px.green);
        chan[2] = 32'(px.blue);
        chan[3] = 32'(px.alpha);
        row_end      = (pos_x + 1 >= w);
        col_end      = (col_in_blk + 1 >= f) || row_end;
        at_bottom    = (pos_y + 1 >= h);
        blockrow_end = (row_in_blk + 1 >= f) || at_bottom;

        // first pixel of a block overwrites the column entry, the rest add in
        for (int c = 0; c < 4; c++) begin
            if (row_in_blk == 0 && col_in_blk == 0)
                col_sum[out_col][c] = chan[c];
            else
                col_sum[out_col][c] = col_sum[out_col][c] + chan[c];
        end

        if (col_end && blockrow_end) begin
            n = (col_in_blk + 1) * (row_in_blk + 1);
            for (int c = 0; c < 4; c++) begin
                q = col_sum[out_col][c] / n;
                mean[c] = (q > 255) ? MEAN_MAX : 8'(q);
            end
            if (mean[3] != ALPHA_OPAQUE) translucent = 1'b1;
            res.color565         = {mean[0][7:3], mean[1][7:2], mean[2][7:3]};
            res.alpha_out        = mean[3];
            res.translucent_seen = translucent;
            res.last_pixel       = row_end && at_bottom;
            expected_pixels.insert(expected_pixels.size(), res);
        end

        // advance the raster position
        if (row_end) begin
            pos_x      = 0;
            col_in_blk = 0;
            out_col    = 0;
            if (at_bottom) begin
                begin_new_image();
            end else begin
                pos_y++;
                row_in_blk = blockrow_end ? 0 : row_in_blk + 1;
            end
        end else begin
            pos_x++;
            if (col_end) begin
                col_in_blk = 0;
                out_col    = (out_col + 1) % OUT_COLS;
            end else begin
                col_in_blk++;
            end
        end
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic void check_result();
        scaled_pixel_t want;
        if (expected_pixels.size() == 0) begin
            note_failure($sformatf("unexpected word color %h alpha %h seen %b last %b",
                                   m_tdata[15:0], m_tdata[23:16], m_tuser, m_tlast));
            return;
        end
        want = expected_pixels.pop_front();
        results_checked++;
        if (m_tdata[15:0] !== want.color565 || m_tdata[23:16] !== want.alpha_out ||
            m_tuser !== want.translucent_seen || m_tlast !== want.last_pixel) begin
            note_failure($sformatf(
                "got color %h alpha %h seen %b last %b, expected %h %h %b %b",
                m_tdata[15:0], m_tdata[23:16], m_tuser, m_tlast,
                want.color565, want.alpha_out, want.translucent_seen, want.last_pixel));
        end
    endfunction

    function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.alpha = a;
        return px;
    endfunction

    // channel values lean toward the rails
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel(int unsigned opaque_pct);
        logic [7:0] a;
        a = ($urandom_range(0, 99) < opaque_pct) ? ALPHA_OPAQUE : random_channel();
        return make_pixel(random_channel(), random_channel(), random_channel(), a);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_size();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'(SOURCE_MAX);
            3:       return '1;
            default: return 13'($urandom_range(SOURCE_MAX + 1, 8190));
        endcase
    endfunction

    // output side: stall a random number of cycles on each word unless sink_fast is set
    int unsigned sink_hold = 0;
    int unsigned sink_draw;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            sink_draw = sink_fast ? 0 : $urandom_range(0, 6);
            sink_hold <= sink_draw;
            m_tready  <= (sink_draw == 0);
        end else if (m_tvalid && sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else if (sink_hold == 0) begin
            m_tready <= 1'b1;
        end
    end

    // compare every accepted output word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_pixel(pixel_t px);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        downscale_pixel(px);
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_pixels.size() != 0);
    endtask

    // pixels that close no block may still be in flight after the last word
    task automatic wait_idle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no drop
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_SOURCE_WIDTH:  reg_width  = value;
            CFG_SOURCE_HEIGHT: reg_height = value;
            CFG_SHRINK_FACTOR: reg_factor = value[FACTOR_REG_W-1:0];
            default:           return;
        endcase
        begin_new_image();
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] height,
                             logic [CFG_DATA_W-1:0] factor);
        write_reg(CFG_SOURCE_WIDTH, width);
        write_reg(CFG_SOURCE_HEIGHT, height);
        write_reg(CFG_SHRINK_FACTOR, factor);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_image(int unsigned count, int unsigned opaque_pct);
        for (int unsigned i = 0; i < count; i++) begin
            // now and then hold the source until the output side has caught up
            if ($urandom_range(0, 63) == 0) wait_for_results();
            send_pixel(random_pixel(opaque_pct));
        end
    endtask

    // out of reset the block is a 1x1 image with factor 1
    task automatic test_reset_defaults();
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'hA5, 8'h5A, 8'h81, 8'hFE));
    endtask

    // zero width, height and factor behave as one
    task automatic test_zero_registers();
        wait_idle();
        configure('0, '0, '0);
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'h00));
    endtask

    // 3x3 image at factor 2: full, right, bottom and corner blocks, then a
    // factor wider than the whole image
    task automatic test_partial_blocks();
        wait_idle();
        configure(13'd3, 13'd3, 13'd2);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) begin
                // an unused index must leave the scan position alone
                wait_idle();
                write_reg(CFG_UNUSED, '1);
                cfg_valid <= 1'b0;
            end
            send_pixel(make_pixel(8'(255 - 29 * i), 8'(31 * i), 8'(200 + 7 * i),
                                  (i == 8) ? 8'h00 : 8'hFF));
        end
        wait_idle();
        configure(13'd3, 13'd2, 13'd5);
        for (int i = 0; i < 6; i++) begin
            if (i == 2) send_pixel(make_pixel(8'h00, 8'h80, 8'h01, 8'hFE));
            else        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        end
    endtask

    // oversize width and factor saturate: factor 31 acts as 16 along a wide row
    task automatic test_register_saturation();
        wait_idle();
        configure('1, 13'd1, 13'd31);
        send_image(40, 95);
    endtask

    // 513 output columns: the last one shares a store entry with the first,
    // seen when the first block of the second row closes
    task automatic test_column_alias();
        wait_idle();
        configure(13'd1026, 13'd2, 13'd2);
        src_fast  = 1'b1;
        sink_fast = 1'b1;
        send_image(1028, 100);
        wait_for_results();
        src_fast  = 1'b0;
        sink_fast = 1'b0;
    endtask

    // mostly small images, some cut short, some at extreme register values
    task automatic test_random_images();
        int unsigned start, count, opaque_pct;
        logic [CFG_DATA_W-1:0] width, height, factor;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            src_fast  = ($urandom_range(0, 4) == 0);
            sink_fast = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 11) == 0) begin
                    width  = extreme_size();
                    height = extreme_size();
                    case ($urandom_range(0, 3))
                        0:       factor = '0;
                        1:       factor = 13'd1;
                        2:       factor = 13'(FACTOR_MAX);
                        default: factor = 13'd31;
                    endcase
                end else begin
                    width  = 13'($urandom_range(1, 20));
                    height = 13'($urandom_range(1, 10));
                    if ($urandom_range(0, 9) == 0) factor = 13'($urandom_range(0, 31));
                    else                           factor = 13'($urandom_range(1, 6));
                end
                // data bits above the factor register are dropped
                if ($urandom_range(0, 3) == 0) factor = factor | (13'($urandom) & 13'h1FE0);
                wait_idle();
                configure(width, height, factor);
            end
            count = clamp_size(32'(reg_width), SOURCE_MAX) *
                    clamp_size(32'(reg_height), SOURCE_MAX);
            if (count > 300) count = 300;
            if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
            case ($urandom_range(0, 2))
                0:       opaque_pct = 100;
                1:       opaque_pct = 98;
                default: opaque_pct = 40;
            endcase
            send_image(count, opaque_pct);
        end
        src_fast  = 1'b0;
        sink_fast = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_registers();
        test_partial_blocks();
        test_register_saturation();
        test_column_alias();
        test_random_images();
        wait_idle();
        $display("sent %0d source pixels, checked %0d averaged pixels, %0d register writes",
                 pixels_sent, results_checked, reg_writes);
        $display("edge blocks, column wrap, saturated registers, restarts; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== box_average_image_downscaler.f =====
rtl/bad_pkg.sv
rtl/box_average_image_downscaler.sv
rtl/bad_checker.sv
tb/testbench.sv
